// ===== hw/rtl/civil_date_seconds_converter_macros.svh =====
// assertion helpers for the date and seconds converter
`ifndef CIVIL_DATE_SECONDS_CONVERTER_MACROS_SVH
`define CIVIL_DATE_SECONDS_CONVERTER_MACROS_SVH

// same-cycle implication, held off during reset
`define CDSC_ASSERT_IMPL(name, clock, reset, cond, expr) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("cdsc assertion failed");

// next-cycle implication, held off during reset
`define CDSC_ASSERT_NEXT(name, clock, reset, cond, expr) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("cdsc assertion failed");

`endif

// ===== hw/rtl/cdsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdsc_pkg;

  // pipeline depth shared by both conversion paths
  localparam int STAGES = 10;

  // calendar limits
  localparam logic [13:0] MIN_YEAR_RESET = 14'd2024;
  localparam logic [13:0] MAX_YEAR       = 14'd9999;
  localparam logic [13:0] EPOCH_YEAR     = 14'd1970;
  localparam logic [37:0] MAX_SECONDS    = 38'd253402300799;

  // day and time constants
  localparam logic [19:0] EPOCH_SHIFT_DAYS = 20'd719468;
  localparam logic [17:0] DAYS_PER_ERA     = 18'd146097;
  localparam logic [17:0] DAYS_PER_CENT    = 18'd36524;
  localparam logic [17:0] LAST_DAY_OF_ERA  = 18'd146096;
  localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
  localparam logic [8:0]  YEARS_PER_ERA    = 9'd400;
  localparam logic [6:0]  YEARS_PER_CENT   = 7'd100;
  localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN     = 6'd60;
  localparam logic [9:0]  SECS_DAY_ODD     = 10'd675;  // 86400 = 675 * 128

  // reciprocals for constant divides: q = (x * R) >> S, exact over the input width
  localparam logic [12:0] RECIP_100_Y = 13'd5243;       // x < 2^14, shift 19
  localparam logic [31:0] RECIP_675   = 32'd3257812231; // x < 2^31, shift 41
  localparam logic [22:0] RECIP_ERA   = 23'd7525902;    // x < 2^23, shift 40
  localparam logic [13:0] RECIP_225   = 14'd9321;       // x < 2^13, shift 21
  localparam logic [10:0] RECIP_15    = 11'd1093;       // x < 2^10, shift 14
  localparam logic [16:0] RECIP_365_S = 17'd91930;      // x < 2^16, shift 25
  localparam logic [18:0] RECIP_365_L = 19'd367720;     // x < 2^18, shift 27
  localparam logic [9:0]  RECIP_100_E = 10'd656;        // x < 2^9, shift 16
  localparam logic [12:0] RECIP_153   = 13'd6854;       // x < 2^12, shift 20

  // one stage enable per pipeline stage
  typedef logic [STAGES-1:0] stage_en_t;

  // civil date and time of day
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  // days from march 1 to the first of the month, month counted from march
  function automatic logic [8:0] month_start(input logic [3:0] mshift);
    logic [8:0] r;
    unique case (mshift)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // length of a calendar month
  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] r;
    unique case (mo) inside
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cdsc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface cdsc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [37:0] seconds_in;

  modport source (
    output valid, req_type, year, month, day, hour, minute, second, seconds_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, year, month, day, hour, minute, second, seconds_in,
    output ready
  );
endinterface

// result channel
interface cdsc_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [37:0] seconds_out;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  modport source (
    output valid, valid_res, seconds_out, year_out, month_out, day_out,
           hour_out, minute_out, second_out,
    input  ready
  );
  modport sink (
    input  valid, valid_res, seconds_out, year_out, month_out, day_out,
           hour_out, minute_out, second_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/cdsc_to_secs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// date and time to seconds since 1970, three working stages then a delay line
module cdsc_to_secs (
  input  wire logic                clk,
  input  wire cdsc_pkg::stage_en_t en,
  input  wire cdsc_pkg::date_t     date,
  input  wire logic [13:0]         min_year,
  output logic                     ok,
  output logic [37:0]              seconds
);

  localparam int LAST = cdsc_pkg::STAGES - 1;

  // stage 0: range checks, march-based year, divide-by-100 products
  logic        early;
  logic [13:0] y_c;
  logic        ok0;
  logic [13:0] y0;
  logic [13:0] yr0;
  logic [26:0] prod_y0;
  logic [26:0] prod_yr0;
  logic [3:0]  mo0;
  logic [4:0]  dy0;
  logic [4:0]  hr0;
  logic [5:0]  mi0;
  logic [5:0]  se0;

  assign early = date.month <= 4'd2;
  assign y_c   = 14'(date.year - 14'(early));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok0 <= date.month >= 4'd1 && date.month <= 4'd12 &&
             date.year <= cdsc_pkg::MAX_YEAR && date.year >= cdsc_pkg::EPOCH_YEAR &&
             date.year >= min_year && date.day != 5'd0 &&
             date.hour <= 5'd23 && date.minute <= 6'd59 && date.second <= 6'd59;
      y0       <= y_c;
      yr0      <= date.year;
      prod_y0  <= 27'(y_c) * 27'(cdsc_pkg::RECIP_100_Y);
      prod_yr0 <= 27'(date.year) * 27'(cdsc_pkg::RECIP_100_Y);
      mo0      <= date.month;
      dy0      <= date.day;
      hr0      <= date.hour;
      mi0      <= date.minute;
      se0      <= date.second;
    end
  end

  // stage 1: leap rule, month length, day count and time of day
  logic [7:0]  q_y;
  logic [7:0]  q_yr;
  logic [6:0]  rem_yr;
  logic        leap;
  logic [3:0]  mshift;
  logic [22:0] days_c;
  logic [16:0] tod_c;
  logic        ok1;
  logic [21:0] days1;
  logic [16:0] tod1;

  assign q_y    = prod_y0[26:19];
  assign q_yr   = prod_yr0[26:19];
  assign rem_yr = 7'(yr0 - 14'(q_yr) * 14'(cdsc_pkg::YEARS_PER_CENT));
  assign leap   = yr0[1:0] == 2'd0 && (rem_yr != 7'd0 || q_yr[1:0] == 2'd0);
  assign mshift = (mo0 > 4'd2) ? 4'(mo0 - 4'd3) : 4'(mo0 + 4'd9);

  assign days_c = 23'(y0) * 23'(cdsc_pkg::DAYS_PER_YEAR) + 23'(y0[13:2]) - 23'(q_y) +
                  23'(q_y[7:2]) + 23'(cdsc_pkg::month_start(mshift)) + 23'(dy0) -
                  23'd1 - 23'(cdsc_pkg::EPOCH_SHIFT_DAYS);
  assign tod_c  = 17'(hr0) * 17'(cdsc_pkg::SECS_PER_HOUR) +
                  17'(mi0) * 17'(cdsc_pkg::SECS_PER_MIN) + 17'(se0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok1   <= ok0 && dy0 <= cdsc_pkg::month_days(mo0, leap);
      days1 <= days_c[21:0];
      tod1  <= tod_c;
    end
  end

  // stage 2: scale days to seconds, then carry to the output stage
  logic        ok_pipe   [2:LAST];
  logic [37:0] secs_pipe [2:LAST];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ok_pipe[2]   <= ok1;
      secs_pipe[2] <= 38'(39'(days1) * 39'(cdsc_pkg::SECS_PER_DAY) + 39'(tod1));
    end
    for (int k = 3; k <= LAST; k++) begin
      if (en[k]) begin
        ok_pipe[k]   <= ok_pipe[k-1];
        secs_pipe[k] <= secs_pipe[k-1];
      end
    end
  end

  assign ok      = ok_pipe[LAST];
  assign seconds = secs_pipe[LAST];

endmodule

`default_nettype wire

// ===== hw/rtl/cdsc_to_date.sv =====
`timescale 1ns / 1ps
`default_nettype none

// seconds since 1970 to date and time, a chain of constant divides spread over the stages
module cdsc_to_date (
  input  wire logic                clk,
  input  wire cdsc_pkg::stage_en_t en,
  input  wire logic [37:0]         seconds_in,
  output logic                     ok,
  output cdsc_pkg::date_t          date
);

  localparam int LAST = cdsc_pkg::STAGES - 1;
  localparam logic [17:0] CENT2 = 18'(2 * cdsc_pkg::DAYS_PER_CENT);
  localparam logic [17:0] CENT3 = 18'(3 * cdsc_pkg::DAYS_PER_CENT);

  logic ok_pipe [0:LAST];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok_pipe[0] <= seconds_in <= cdsc_pkg::MAX_SECONDS;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (en[k]) begin
        ok_pipe[k] <= ok_pipe[k-1];
      end
    end
  end

  // stage 0: day count, seconds / 86400 as (seconds / 128) / 675
  logic [62:0] prod_days;
  logic [21:0] days0;
  logic [16:0] slo0;

  assign prod_days = 63'(seconds_in[37:7]) * 63'(cdsc_pkg::RECIP_675);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      days0 <= prod_days[62:41];
      slo0  <= seconds_in[16:0];
    end
  end

  // stage 1: shift to a march-based day count, seconds of the day
  logic [9:0]  day_lo;
  logic [22:0] z1;
  logic [16:0] sod1;

  assign day_lo = 10'(days0[9:0] * cdsc_pkg::SECS_DAY_ODD);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      z1   <= 23'(days0) + 23'(cdsc_pkg::EPOCH_SHIFT_DAYS);
      sod1 <= 17'(slo0 - {day_lo, 7'd0});
    end
  end

  // stage 2: era and hour
  logic [45:0] prod_era;
  logic [26:0] prod_hr;
  logic [22:0] z2;
  logic [5:0]  era2;
  logic [16:0] sod2;
  logic [4:0]  hr_pipe [2:LAST];

  assign prod_era = 46'(z1) * 46'(cdsc_pkg::RECIP_ERA);
  assign prod_hr  = 27'(sod1[16:4]) * 27'(cdsc_pkg::RECIP_225);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      z2         <= z1;
      era2       <= prod_era[45:40];
      sod2       <= sod1;
      hr_pipe[2] <= prod_hr[25:21];
    end
    for (int k = 3; k <= LAST; k++) begin
      if (en[k]) begin
        hr_pipe[k] <= hr_pipe[k-1];
      end
    end
  end

  // stage 3: day of era, seconds within the hour
  logic [17:0] doe3;
  logic [5:0]  era3;
  logic [11:0] remh3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      doe3  <= 18'(24'(z2) - 24'(era2) * 24'(cdsc_pkg::DAYS_PER_ERA));
      era3  <= era2;
      remh3 <= 12'(sod2 - 17'(hr_pipe[2]) * 17'(cdsc_pkg::SECS_PER_HOUR));
    end
  end

  // stage 4: leap corrections of the era and minute
  logic [32:0] prod_a;
  logic [20:0] prod_mn;
  logic [17:0] doe4;
  logic [5:0]  era4;
  logic [11:0] remh4;
  logic [7:0]  a4;
  logic [2:0]  b4;
  logic        c4;
  logic [5:0]  mn_pipe [4:LAST];

  assign prod_a  = 33'(doe3[17:2]) * 33'(cdsc_pkg::RECIP_365_S);
  assign prod_mn = 21'(remh3[11:2]) * 21'(cdsc_pkg::RECIP_15);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      doe4       <= doe3;
      era4       <= era3;
      remh4      <= remh3;
      a4         <= prod_a[32:25];
      b4         <= 3'(doe3 >= cdsc_pkg::DAYS_PER_CENT) + 3'(doe3 >= CENT2) +
                    3'(doe3 >= CENT3) + 3'(doe3 >= cdsc_pkg::LAST_DAY_OF_ERA);
      c4         <= doe3 >= cdsc_pkg::LAST_DAY_OF_ERA;
      mn_pipe[4] <= prod_mn[19:14];
    end
    for (int k = 5; k <= LAST; k++) begin
      if (en[k]) begin
        mn_pipe[k] <= mn_pipe[k-1];
      end
    end
  end

  // stage 5: day count with leap days removed, second
  logic [17:0] t5;
  logic [17:0] doe5;
  logic [5:0]  era5;
  logic [5:0]  sec_pipe [5:LAST];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      t5          <= 18'(doe4 - 18'(a4) + 18'(b4) - 18'(c4));
      doe5        <= doe4;
      era5        <= era4;
      sec_pipe[5] <= 6'(remh4 - 12'(mn_pipe[4]) * 12'(cdsc_pkg::SECS_PER_MIN));
    end
    for (int k = 6; k <= LAST; k++) begin
      if (en[k]) begin
        sec_pipe[k] <= sec_pipe[k-1];
      end
    end
  end

  // stage 6: year of era
  logic [36:0] prod_yoe;
  logic [8:0]  yoe6;
  logic [17:0] doe6;
  logic [5:0]  era6;

  assign prod_yoe = 37'(t5) * 37'(cdsc_pkg::RECIP_365_L);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      yoe6 <= prod_yoe[35:27];
      doe6 <= doe5;
      era6 <= era5;
    end
  end

  // stage 7: day of the march-based year, march-based year
  logic [18:0] prod_q;
  logic [2:0]  q100;
  logic [17:0] year_days;
  logic [8:0]  doy7;
  logic [13:0] y7;

  assign prod_q    = 19'(yoe6) * 19'(cdsc_pkg::RECIP_100_E);
  assign q100      = prod_q[18:16];
  assign year_days = 18'(yoe6) * 18'(cdsc_pkg::DAYS_PER_YEAR) + 18'(yoe6[8:2]) - 18'(q100);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      doy7 <= 9'(doe6 - year_days);
      y7   <= 14'(14'(yoe6) + 14'(era6) * 14'(cdsc_pkg::YEARS_PER_ERA));
    end
  end

  // stage 8: month counted from march
  logic [11:0] mp_num;
  logic [24:0] prod_mp;
  logic [3:0]  mp8;
  logic [8:0]  doy8;
  logic [13:0] y8;

  assign mp_num  = 12'(12'(doy7) * 12'd5 + 12'd2);
  assign prod_mp = 25'(mp_num) * 25'(cdsc_pkg::RECIP_153);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      mp8  <= prod_mp[23:20];
      doy8 <= doy7;
      y8   <= y7;
    end
  end

  // stage 9: calendar month, day and year
  logic [3:0]  m_c;
  logic [13:0] year9;
  logic [3:0]  month9;
  logic [4:0]  day9;

  assign m_c = (mp8 < 4'd10) ? 4'(mp8 + 4'd3) : 4'(mp8 - 4'd9);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      year9  <= 14'(y8 + 14'(m_c <= 4'd2));
      month9 <= m_c;
      day9   <= 5'(doy8 - cdsc_pkg::month_start(mp8) + 9'd1);
    end
  end

  assign ok          = ok_pipe[LAST];
  assign date.year   = year9;
  assign date.month  = month9;
  assign date.day    = day9;
  assign date.hour   = hr_pipe[LAST];
  assign date.minute = mn_pipe[LAST];
  assign date.second = sec_pipe[LAST];

endmodule

`default_nettype wire

// ===== hw/rtl/civil_date_seconds_converter.sv =====
// channel  side  handshake          payload
// req      in    valid / ready      req_type, year .. second, seconds_in
// res      out   valid / ready      valid_res, seconds_out, year_out .. second_out
// cfg      in    cfg_we, no wait    cfg_wdata -> min_year
//
// one beat per cycle sustained while res takes its results; a result is offered once
// its beat reaches the last register stage; depth is set by the seconds to date divide chain,
// spread over ten register stages, with the date to seconds side padded to match.
// reset clears the stage valid bits and loads min_year with 2024; there is no memory.
// each stage holds while the one after it is full and stalled, so bubbles close up;
// req.ready drops only when every stage holds a beat and res is not taken.
`timescale 1ns / 1ps
`default_nettype none
`include "civil_date_seconds_converter_macros.svh"

module civil_date_seconds_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [13:0] cfg_wdata,
  cdsc_req_if.sink         req,
  cdsc_res_if.source       res
);

  localparam int LAST = cdsc_pkg::STAGES - 1;

  // configuration register
  logic [13:0] min_year;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= cdsc_pkg::MIN_YEAR_RESET;
    end else if (cfg_we) begin
      min_year <= cfg_wdata;
    end
  end

  // stage enables: a stage loads when it is empty or the next one moves
  cdsc_pkg::stage_en_t en;
  logic [LAST:0]       v;
  logic [LAST:0]       rq;

  always_comb begin
    en[LAST] = !v[LAST] || res.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign req.ready = en[0];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req.valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // direction travels with each beat
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rq[0] <= req.req_type;
    end
    for (int k = 1; k <= LAST; k++) begin
      if (en[k]) begin
        rq[k] <= rq[k-1];
      end
    end
  end

  // both directions run on every beat
  cdsc_pkg::date_t req_date;
  cdsc_pkg::date_t d_date;
  logic            s_ok;
  logic [37:0]     s_secs;
  logic            d_ok;

  assign req_date = '{year: req.year, month: req.month, day: req.day,
                      hour: req.hour, minute: req.minute, second: req.second};

  cdsc_to_secs u_secs (
    .clk      (clk),
    .en       (en),
    .date     (req_date),
    .min_year (min_year),
    .ok       (s_ok),
    .seconds  (s_secs)
  );

  cdsc_to_date u_date (
    .clk        (clk),
    .en         (en),
    .seconds_in (req.seconds_in),
    .ok         (d_ok),
    .date       (d_date)
  );

  // pick the result of the requested direction, zero the unused fields
  logic to_date;
  logic secs_good;
  logic date_good;

  assign to_date   = rq[LAST];
  assign secs_good = !to_date && s_ok;
  assign date_good = to_date && d_ok;

  assign res.valid       = v[LAST];
  assign res.valid_res   = to_date ? d_ok : s_ok;
  assign res.seconds_out = secs_good ? s_secs : '0;
  assign res.year_out    = date_good ? d_date.year : '0;
  assign res.month_out   = date_good ? d_date.month : '0;
  assign res.day_out     = date_good ? d_date.day : '0;
  assign res.hour_out    = date_good ? d_date.hour : '0;
  assign res.minute_out  = date_good ? d_date.minute : '0;
  assign res.second_out  = date_good ? d_date.second : '0;

  // result field summaries for the checks
  logic res_blank;
  logic date_sane;

  assign res_blank = res.seconds_out == '0 && res.year_out == '0 && res.month_out == '0;
  assign date_sane = res.month_out >= 4'd1 && res.month_out <= 4'd12 && res.day_out != 5'd0;

  // checks
  `CDSC_ASSERT_IMPL(a_full_stall, clk, rst, (&v) && !res.ready, !req.ready)
  `CDSC_ASSERT_IMPL(a_reject_zero, clk, rst, res.valid && !res.valid_res, res_blank)
  `CDSC_ASSERT_IMPL(a_date_fields, clk, rst, res.valid && res.valid_res && to_date, date_sane)
  `CDSC_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_we, min_year == $past(cfg_wdata))

endmodule

`default_nettype wire

// ===== sim/cdsc_tb_pkg.sv =====
`timescale 1ns / 1ps

package cdsc_tb_pkg;

  // conversion direction carried in req_type
  typedef enum logic {
    DATE_TO_SECS = 1'b0,
    SECS_TO_DATE = 1'b1
  } conv_dir_e;

  // one request beat
  typedef struct packed {
    conv_dir_e        dir;
    cdsc_pkg::date_t  date;
    logic [37:0]      seconds_in;
  } conv_req_t;

  // one result beat, date fields map onto year_out .. second_out
  typedef struct packed {
    logic             valid_res;
    logic [37:0]      seconds_out;
    cdsc_pkg::date_t  date;
  } conv_res_t;

  // day arithmetic for the civil calendar
  localparam longint ERA_DAYS    = 146097;
  localparam longint EPOCH_SHIFT = 719468;
  localparam longint DAY_SECS    = 86400;
  localparam longint LAST_YEAR   = 9999;

  // month length with gregorian leap rules, month 1..12
  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

endpackage

// ===== sim/cdsc_result_checker.sv =====
`timescale 1ns / 1ps

module cdsc_result_checker
  import cdsc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  cdsc_req_if         req,
  cdsc_res_if         res,
  output int          fail_count,
  output int          pending,
  output int          checked_count
);

  conv_res_t   predicted_results[$];
  logic [13:0] floor_year = cdsc_pkg::MIN_YEAR_RESET;
  int          fails = 0;
  int          checked = 0;

  // expected result of one conversion under the given least year
  function automatic conv_res_t predict_conversion(conv_req_t q, logic [13:0] least_year);
    conv_res_t r;
    longint yr, mo, dy, hr, mi, se;
    longint yy, era, yoe, doy, doe, days, mshift, total, sod, z, mp, dd, mm;
    r = '0;
    yr = q.date.year;
    mo = q.date.month;
    dy = q.date.day;
    hr = q.date.hour;
    mi = q.date.minute;
    se = q.date.second;
    if (q.dir == DATE_TO_SECS) begin
      // validity: month, year window, day within month, time of day
      if (mo < 1 || mo > 12 || yr > LAST_YEAR || yr < least_year) return r;
      if (dy < 1 || dy > days_in_month(32'(yr), 32'(mo))) return r;
      if (hr > 23 || mi > 59 || se > 59) return r;
      // days from epoch, years counted from march
      yy = yr - ((mo <= 2) ? 1 : 0);
      era = ((yy >= 0) ? yy : yy - 399) / 400;
      yoe = yy - era * 400;
      mshift = (mo > 2) ? mo - 3 : mo + 9;
      doy = (153 * mshift + 2) / 5 + dy - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * ERA_DAYS + doe - EPOCH_SHIFT;
      // dates before the epoch are rejected
      if (days < 0) return r;
      r.valid_res = 1'b1;
      r.seconds_out = 38'(days * DAY_SECS + hr * 3600 + mi * 60 + se);
    end else begin
      // counts past the last second of year 9999 are rejected
      if (q.seconds_in > cdsc_pkg::MAX_SECONDS) return r;
      total = q.seconds_in;
      days = total / DAY_SECS;
      sod = total % DAY_SECS;
      z = days + EPOCH_SHIFT;
      era = z / ERA_DAYS;
      doe = z - era * ERA_DAYS;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yy = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      dd = doy - (153 * mp + 2) / 5 + 1;
      mm = (mp < 10) ? mp + 3 : mp - 9;
      if (mm <= 2) yy++;
      r.valid_res = 1'b1;
      r.date.year = 14'(yy);
      r.date.month = 4'(mm);
      r.date.day = 5'(dd);
      r.date.hour = 5'(sod / 3600);
      r.date.minute = 6'((sod / 60) % 60);
      r.date.second = 6'(sod % 60);
    end
    return r;
  endfunction

  // one field compare, returns 1 on mismatch
  function automatic int field_mismatch(string name, longint unsigned want,
                                        longint unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    conv_req_t seen;
    conv_res_t want, got;
    if (rst) begin
      floor_year = cdsc_pkg::MIN_YEAR_RESET;
      predicted_results.delete();
    end else begin
      // result beat against the oldest prediction
      if (res.valid && res.ready) begin
        got.valid_res = res.valid_res;
        got.seconds_out = res.seconds_out;
        got.date.year = res.year_out;
        got.date.month = res.month_out;
        got.date.day = res.day_out;
        got.date.hour = res.hour_out;
        got.date.minute = res.minute_out;
        got.date.second = res.second_out;
        if (predicted_results.size() == 0) begin
          $error("result beat with no request outstanding");
          fails++;
        end else begin
          want = predicted_results.pop_front();
          checked++;
          fails += field_mismatch("valid_res", want.valid_res, got.valid_res);
          fails += field_mismatch("seconds_out", want.seconds_out, got.seconds_out);
          fails += field_mismatch("year_out", want.date.year, got.date.year);
          fails += field_mismatch("month_out", want.date.month, got.date.month);
          fails += field_mismatch("day_out", want.date.day, got.date.day);
          fails += field_mismatch("hour_out", want.date.hour, got.date.hour);
          fails += field_mismatch("minute_out", want.date.minute, got.date.minute);
          fails += field_mismatch("second_out", want.date.second, got.date.second);
        end
      end
      // request beat taken, predict under the current least year
      if (req.valid && req.ready) begin
        seen.dir = conv_dir_e'(req.req_type);
        seen.date.year = req.year;
        seen.date.month = req.month;
        seen.date.day = req.day;
        seen.date.hour = req.hour;
        seen.date.minute = req.minute;
        seen.date.second = req.second;
        seen.seconds_in = req.seconds_in;
        predicted_results.push_back(predict_conversion(seen, floor_year));
      end
      // register write lands at this edge
      if (cfg_we) floor_year = cfg_wdata;
    end
    fail_count <= fails;
    pending <= predicted_results.size();
    checked_count <= checked;
  end

endmodule

// ===== sim/civil_date_seconds_converter_tb.sv =====
`timescale 1ns / 1ps

module civil_date_seconds_converter_tb;
  import cdsc_tb_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int BEATS_PER_STEP = 185;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_BEATS     = 40;
  localparam int SETTLE_CYCLES  = 20;
  localparam int LAST_DAY       = 2932896;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [13:0] cfg_wdata;
  logic        hold_start;
  logic [13:0] floor_year = cdsc_pkg::MIN_YEAR_RESET;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycle_count = 0;
  int          fail_count, pending, checked_count;
  int          n_to_secs = 0;
  int          n_to_date = 0;
  int          n_settings = 0;

  cdsc_req_if req();
  cdsc_res_if res();

  civil_date_seconds_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .res       (res)
  );

  cdsc_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req           (req),
    .res           (res),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [37:0] rand_count();
    return 38'({$urandom, $urandom});
  endfunction

  // date to seconds beat, unused count field random
  function automatic conv_req_t date_req(int unsigned y, int unsigned m, int unsigned d,
                                         int unsigned h, int unsigned mi, int unsigned s);
    conv_req_t item;
    item.dir = DATE_TO_SECS;
    item.date.year = 14'(y);
    item.date.month = 4'(m);
    item.date.day = 5'(d);
    item.date.hour = 5'(h);
    item.date.minute = 6'(mi);
    item.date.second = 6'(s);
    item.seconds_in = rand_count();
    return item;
  endfunction

  // seconds to date beat, unused date fields random
  function automatic conv_req_t secs_req(longint unsigned v);
    conv_req_t item;
    item.dir = SECS_TO_DATE;
    item.date = cdsc_pkg::date_t'(40'({$urandom, $urandom}));
    item.seconds_in = 38'(v);
    return item;
  endfunction

  // random mix: mostly well-formed dates and counts, some broken and noise
  function automatic conv_req_t random_request();
    conv_req_t item;
    int unsigned pick, lo, y, m, d, last;
    longint unsigned span;
    pick = $urandom_range(99);
    lo = (floor_year > 9999) ? 9999 : floor_year;
    case ($urandom_range(3))
      0: y = lo + $urandom_range(3);
      1: y = 9999 - $urandom_range(3);
      default: y = $urandom_range(9999, lo);
    endcase
    if (y > 9999) y = 9999;
    if (y < lo) y = lo;
    m = $urandom_range(12, 1);
    last = days_in_month(y, m);
    d = ($urandom_range(3) == 0) ? last : $urandom_range(last, 1);
    item = date_req(y, m, d, $urandom_range(23), $urandom_range(59), $urandom_range(59));
    if (pick < 45) return item;
    // one field pushed out of range
    if (pick < 55) begin
      case ($urandom_range(6))
        0: item.date.month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
        1: item.date.day = (last == 31 || $urandom_range(1)) ? 5'd0
                           : 5'($urandom_range(31, last + 1));
        2: item.date.hour = 5'($urandom_range(31, 24));
        3: item.date.minute = 6'($urandom_range(63, 60));
        4: item.date.second = 6'($urandom_range(63, 60));
        5: item.date.year = 14'($urandom_range(16383, 10000));
        default: item.date.year = (lo == 0) ? 14'd16383 : 14'($urandom_range(lo - 1));
      endcase
      return item;
    end
    if (pick < 60) begin
      return date_req($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                      $urandom_range(31), $urandom_range(63), $urandom_range(63));
    end
    // counts in range, biased to the ends and to day boundaries
    if (pick < 90) begin
      case ($urandom_range(3))
        0: span = $urandom_range(3 * 86400);
        1: span = cdsc_pkg::MAX_SECONDS - $urandom_range(3 * 86400);
        2: begin
          span = 64'($urandom_range(LAST_DAY)) * 86400;
          if ($urandom_range(1) && span != 0) span--;
        end
        default: span = {$urandom, $urandom} % (cdsc_pkg::MAX_SECONDS + 1);
      endcase
      return secs_req(span);
    end
    // counts past the last valid second
    if ($urandom_range(1)) return secs_req(cdsc_pkg::MAX_SECONDS + 1 + $urandom_range(1000));
    return secs_req(rand_count());
  endfunction

  // offer one beat, with random idle cycles ahead of it
  task automatic send_beat(input conv_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= item.dir;
    req.year <= item.date.year;
    req.month <= item.date.month;
    req.day <= item.date.day;
    req.hour <= item.date.hour;
    req.minute <= item.date.minute;
    req.second <= item.date.second;
    req.seconds_in <= item.seconds_in;
    do @(posedge clk); while (!req.ready);
    if (item.dir == DATE_TO_SECS) n_to_secs++;
    else n_to_date++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // register write once the pipeline is empty
  task automatic set_min_year(input logic [13:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    floor_year = v;
    n_settings++;
  endtask

  initial begin
    logic [13:0] floor_plan [8];
    int phase, step;
    floor_plan = '{14'd1970, 14'd2024, 14'd9999, 14'd1970,
                   14'd0, 14'd1970, 14'd16383, 14'd1970};
    floor_plan[5] = 14'($urandom_range(9999, 1970));
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_start = 1'b0;
    req.valid = 1'b0;
    req.req_type = DATE_TO_SECS;
    req.year = '0;
    req.month = '0;
    req.day = '0;
    req.hour = '0;
    req.minute = '0;
    req.second = '0;
    req.seconds_in = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // least year still at its reset value
    send_beat(date_req(2023, 12, 31, 23, 59, 59));
    send_beat(date_req(2024, 1, 1, 0, 0, 0));

    // field extremes, leap rules, out-of-range fields and counts
    set_min_year(14'd1970);
    send_beat(date_req(1970, 1, 1, 0, 0, 0));
    send_beat(date_req(9999, 12, 31, 23, 59, 59));
    send_beat(date_req(2000, 2, 29, 12, 30, 45));
    send_beat(date_req(2100, 2, 29, 0, 0, 0));
    send_beat(date_req(2023, 2, 29, 0, 0, 0));
    send_beat(date_req(2024, 2, 29, 6, 7, 8));
    send_beat(date_req(2024, 4, 31, 0, 0, 0));
    send_beat(date_req(2024, 0, 10, 0, 0, 0));
    send_beat(date_req(2024, 13, 1, 0, 0, 0));
    send_beat(date_req(2024, 5, 0, 0, 0, 0));
    send_beat(date_req(2024, 1, 1, 24, 0, 0));
    send_beat(date_req(2024, 1, 1, 0, 0, 63));
    send_beat(date_req(10000, 1, 1, 0, 0, 0));
    send_beat(date_req(16383, 15, 31, 31, 63, 63));
    send_beat(secs_req(0));
    send_beat(secs_req(cdsc_pkg::MAX_SECONDS));
    send_beat(secs_req(cdsc_pkg::MAX_SECONDS + 1));
    send_beat(secs_req(38'h3F_FFFF_FFFF));
    send_beat(secs_req(64'd4102444800));
    send_beat(secs_req(86399));

    // least year below the epoch: pre-1970 dates and year zero
    set_min_year(14'd0);
    send_beat(date_req(1969, 12, 31, 23, 59, 59));
    send_beat(date_req(0, 1, 1, 0, 0, 0));

    // least year past 9999: nothing passes
    set_min_year(14'd16383);
    send_beat(date_req(2024, 6, 15, 12, 0, 0));

    // long receiver hold-off while beats keep coming, so the pipe backs up
    set_min_year(14'd1970);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (HOLD_BEATS) send_beat(random_request());
    wait_drained();

    // random traffic under four pacing modes and eight least-year settings
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct = 37;
          recv_stall_pct = 37;
        end
      endcase
      for (step = 0; step < 2; step++) begin
        set_min_year(floor_plan[phase * 2 + step]);
        repeat (BEATS_PER_STEP) send_beat(random_request());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d date-to-seconds and %0d seconds-to-date requests, %0d min_year writes",
             n_to_secs, n_to_date, n_settings);
    $display("%0d results compared across four pacing modes and one long output hold-off",
             checked_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
